### src/rhpq_pkg.sv
// shared types, constants and handshake structs for the radix heap queue
`default_nettype none
package rhpq_pkg;

  localparam int KEY_W       = 32;
  localparam int CNT_W       = 11;
  localparam int NUM_BUCKETS = 33;
  localparam int BKT_W       = 6;
  localparam int DEF_CAPACITY      = 1024;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  // mode codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] key;
    logic signed [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic signed [31:0] out_payload;
    logic [1:0]         status;
    logic [10:0]        count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic dispatch;
    logic alloc;
    logic bkt_a;
    logic bkt_b;
    logic append;
    logic scan;
    logic pop_ht;
    logic min_ev;
    logic rf_key;
    logic pop_take;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic bsel_zero;
    logic walk_at_end;
    logic rf_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### src/rhpq_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module rhpq_ram #(
  parameter int WIDTH = rhpq_pkg::KEY_W,
  parameter int DEPTH = rhpq_pkg::DEF_CAPACITY
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/rhpq_ctrl.sv
// sequencer for push, bucket scan, re-file and pop
`default_nettype none
module rhpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire rhpq_pkg::sts_t sts,
  output rhpq_pkg::cmd_t     cmd
);
  import rhpq_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISPATCH = 15'b000000000000010,
    S_ALLOC    = 15'b000000000000100,
    S_BKT_A    = 15'b000000000001000,
    S_BKT_B    = 15'b000000000010000,
    S_APPEND   = 15'b000000000100000,
    S_SCAN     = 15'b000000001000000,
    S_POP_HT   = 15'b000000010000000,
    S_MIN_RD   = 15'b000000100000000,
    S_MIN_EV   = 15'b000001000000000,
    S_RF_RD    = 15'b000010000000000,
    S_RF_KEY   = 15'b000100000000000,
    S_POP_RD   = 15'b001000000000000,
    S_POP_TAKE = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (item_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (sts.is_pop)    state_next = S_SCAN;
        else if (sts.full) state_next = S_FIN;
        else               state_next = S_ALLOC;
      end
      S_ALLOC:    state_next = S_BKT_A;
      S_BKT_A:    state_next = S_BKT_B;
      S_BKT_B:    state_next = S_APPEND;
      S_APPEND: begin
        if (!sts.is_pop)      state_next = S_FIN;
        else if (sts.rf_last) state_next = S_SCAN;
        else                  state_next = S_RF_RD;
      end
      S_SCAN:     state_next = sts.empty ? S_FIN : S_POP_HT;
      S_POP_HT:   state_next = sts.bsel_zero ? S_POP_RD : S_MIN_RD;
      S_MIN_RD:   state_next = S_MIN_EV;
      S_MIN_EV:   state_next = sts.walk_at_end ? S_RF_RD : S_MIN_RD;
      S_RF_RD:    state_next = S_RF_KEY;
      S_RF_KEY:   state_next = S_BKT_A;
      S_POP_RD:   state_next = S_POP_TAKE;
      S_POP_TAKE: state_next = S_FIN;
      S_FIN:      if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    item_ready   = (state == S_IDLE);
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && item_valid;
    cmd.dispatch = (state == S_DISPATCH);
    cmd.alloc    = (state == S_ALLOC);
    cmd.bkt_a    = (state == S_BKT_A);
    cmd.bkt_b    = (state == S_BKT_B);
    cmd.append   = (state == S_APPEND);
    cmd.scan     = (state == S_SCAN);
    cmd.pop_ht   = (state == S_POP_HT);
    cmd.min_ev   = (state == S_MIN_EV);
    cmd.rf_key   = (state == S_RF_KEY);
    cmd.pop_take = (state == S_POP_TAKE);
    cmd.load_out = (state == S_FIN) && sts.out_free;
  end

`ifndef SYNTH
  a_push_full_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH && !sts.is_pop && sts.full) |=> (state == S_FIN))
    else $error("full push went on to allocate");
  a_empty_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.empty) |=> (state == S_FIN))
    else $error("empty pop did not finish");
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_DISPATCH))
    else $error("transfer outside idle");
`endif
endmodule
`default_nettype wire

### src/rhpq_dp.sv
// datapath: entry stores, bucket lists, free stack, bucket index unit, result register
`default_nettype none
module rhpq_dp #(
  parameter int CAPACITY      = rhpq_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_WIDTH = rhpq_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rhpq_pkg::in_item_t  item,
  input  wire rhpq_pkg::cmd_t      cmd,
  output rhpq_pkg::sts_t           sts,
  output rhpq_pkg::out_item_t      result,
  output logic                     result_valid,
  input  wire logic                result_ready
);
  import rhpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int HW = $clog2(CAPACITY + 1);

  // item registers
  logic                     mode_r;
  logic signed [31:0]       key_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [PAYLOAD_WIDTH-1:0] pay_in;
  logic [31:0]              pay_out;

  // heap control state
  logic [31:0]      last;
  logic [HW-1:0]    held;
  logic [HW-1:0]    fresh;
  logic [HW-1:0]    free_sp;
  logic [NUM_BUCKETS-1:0] occ;

  // walk and bucket registers
  logic [IW-1:0]    idx_r, walk_r, end_r, head_r, nxt_r;
  logic [BKT_W-1:0] bsel_r, bucket_r;
  logic [31:0]      min_r;
  logic             first_r, rf_last_r;
  logic [31:0]      diff_r;
  logic             le_r, le_b;
  logic [3:0]       nz_r;
  logic [2:0]       bm_r [4];
  logic [2:0]       bm_c [4];

  // result staging
  logic [1:0]       res_st;
  logic [31:0]      res_key, res_pay;

  // ram ports
  logic [31:0]              key_rdata;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;
  logic [IW-1:0]            link_rdata, free_rdata, head_rdata, tail_rdata;
  logic                     link_we, head_we;
  logic [IW-1:0]            link_wdata, head_wdata;
  logic [IW-1:0]            link_waddr;
  logic [BKT_W-1:0]         head_waddr, tail_raddr;

  // combinational helpers
  logic [BKT_W-1:0] b_low, bucket_calc;
  logic             any_occ;
  logic [31:0]      diff_src;
  logic             le_src;
  logic [1:0]       hi_byte;
  logic [31:0]      new_min;
  logic [IW-1:0]    alloc_idx;

  // payload width adaptation
  if (PAYLOAD_WIDTH >= 32) begin : g_wide
    assign pay_in  = PAYLOAD_WIDTH'(unsigned'(item.payload));
    assign pay_out = pay_rdata[31:0];
  end else begin : g_narrow
    assign pay_in  = item.payload[PAYLOAD_WIDTH-1:0];
    assign pay_out = 32'(pay_rdata);
  end

  // lowest occupied bucket
  always_comb begin
    b_low = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (occ[i]) b_low = BKT_W'(i);
    end
    any_occ = |occ;
  end

  // key difference source: pushed key or key read back during re-file
  always_comb begin
    if (cmd.rf_key) begin
      diff_src = key_rdata - last;
      le_src   = $signed(key_rdata) <= $signed(last);
    end else begin
      diff_src = key_r - last;
      le_src   = key_r <= $signed(last);
    end
  end

  // msb position within each byte of the difference
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bm_c[j] = '0;
      for (int k = 0; k < 8; k++) begin
        if (diff_r[8*j + k]) bm_c[j] = 3'(k);
      end
    end
  end

  // bucket index from per-byte msb stage
  always_comb begin
    hi_byte = '0;
    for (int j = 0; j < 4; j++) begin
      if (nz_r[j]) hi_byte = 2'(j);
    end
    bucket_calc = le_b ? '0 : (BKT_W'({hi_byte, bm_r[hi_byte]}) + BKT_W'(1));
  end

  // running minimum of the bucket being drained
  always_comb begin
    if (first_r || ($signed(key_rdata) <= $signed(min_r))) new_min = key_rdata;
    else                                                   new_min = min_r;
  end

  assign alloc_idx = (free_sp != '0) ? free_rdata : IW'(fresh);

  // main datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= item.mode;
      key_r   <= item.key;
      pay_r   <= pay_in;
      res_st  <= ST_OK;
      res_key <= '0;
      res_pay <= '0;
    end
    if (cmd.dispatch && mode_r == MODE_PUSH && held >= HW'(CAPACITY)) res_st <= ST_FULL;
    if (cmd.scan && !(held != '0 && any_occ)) res_st <= ST_EMPTY;
    if (cmd.alloc) begin
      idx_r  <= alloc_idx;
      diff_r <= diff_src;
      le_r   <= le_src;
    end
    if (cmd.rf_key) begin
      idx_r     <= walk_r;
      nxt_r     <= link_rdata;
      rf_last_r <= (walk_r == end_r);
      diff_r    <= diff_src;
      le_r      <= le_src;
    end
    // per-byte nonzero flags and msb positions
    if (cmd.bkt_a) begin
      le_b <= le_r;
      for (int j = 0; j < 4; j++) begin
        nz_r[j] <= |diff_r[8*j +: 8];
        bm_r[j] <= bm_c[j];
      end
    end
    if (cmd.bkt_b)  bucket_r <= bucket_calc;
    if (cmd.append) walk_r   <= nxt_r;
    if (cmd.scan)   bsel_r   <= b_low;
    if (cmd.pop_ht) begin
      head_r  <= head_rdata;
      end_r   <= tail_rdata;
      walk_r  <= head_rdata;
      first_r <= 1'b1;
    end
    if (cmd.min_ev) begin
      min_r   <= new_min;
      first_r <= 1'b0;
      walk_r  <= (walk_r == end_r) ? head_r : link_rdata;
    end
    if (cmd.pop_take) begin
      res_key <= key_rdata;
      res_pay <= pay_out;
    end
    if (cmd.load_out) begin
      result.out_key     <= res_key;
      result.out_payload <= res_pay;
      result.status      <= res_st;
      result.count       <= CNT_W'(held);
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last         <= '0;
      held         <= '0;
      fresh        <= '0;
      free_sp      <= '0;
      occ          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        held <= held + HW'(1);
        if (free_sp != '0) free_sp <= free_sp - HW'(1);
        else               fresh   <= fresh + HW'(1);
      end
      if (cmd.append) occ[bucket_r] <= 1'b1;
      if (cmd.min_ev && walk_r == end_r) begin
        last         <= new_min;
        occ[bsel_r]  <= 1'b0;
      end
      if (cmd.pop_take) begin
        held    <= held - HW'(1);
        free_sp <= free_sp + HW'(1);
        last    <= key_rdata;
        if (walk_r == end_r) occ[0] <= 1'b0;
      end
      if (cmd.load_out)                  result_valid <= 1'b1;
      else if (result_ready)             result_valid <= 1'b0;
    end
  end

  // ram write and read steering
  always_comb begin
    link_we    = cmd.append && occ[bucket_r];
    link_waddr = tail_rdata;
    link_wdata = idx_r;
    head_we    = (cmd.append && !occ[bucket_r]) || (cmd.pop_take && walk_r != end_r);
    head_waddr = cmd.pop_take ? '0 : bucket_r;
    head_wdata = cmd.pop_take ? link_rdata : idx_r;
    tail_raddr = cmd.bkt_b ? bucket_calc : b_low;
  end

  rhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(cmd.append && mode_r == MODE_PUSH), .waddr(idx_r), .wdata(key_r),
    .raddr(walk_r), .rdata(key_rdata));

  rhpq_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(CAPACITY)) u_pay_ram (
    .clk(clk), .we(cmd.append && mode_r == MODE_PUSH), .waddr(idx_r), .wdata(pay_r),
    .raddr(walk_r), .rdata(pay_rdata));

  rhpq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(walk_r), .rdata(link_rdata));

  rhpq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(cmd.pop_take), .waddr(IW'(free_sp)), .wdata(walk_r),
    .raddr(IW'(free_sp - HW'(1))), .rdata(free_rdata));

  rhpq_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(b_low), .rdata(head_rdata));

  rhpq_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_tail_ram (
    .clk(clk), .we(cmd.append), .waddr(bucket_r), .wdata(idx_r),
    .raddr(tail_raddr), .rdata(tail_rdata));

  // status to controller
  always_comb begin
    sts             = '0;
    sts.is_pop      = (mode_r == MODE_POP);
    sts.full        = (held >= HW'(CAPACITY));
    sts.empty       = !(held != '0 && any_occ);
    sts.bsel_zero   = (bsel_r == '0);
    sts.walk_at_end = (walk_r == end_r);
    sts.rf_last     = rf_last_r;
    sts.out_free    = !result_valid || result_ready;
  end

`ifndef SYNTH
  a_held_matches_slots: assert property (@(posedge clk) disable iff (rst)
    held == HW'(fresh - free_sp))
    else $error("held count disagrees with allocated entries");
  a_empty_no_bucket: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (occ == '0))
    else $error("bucket marked occupied on an empty heap");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HW'(CAPACITY))
    else $error("held count beyond capacity");
`endif
endmodule
`default_nettype wire

### src/radix_heap_priority_queue.sv
// top level of the radix heap priority queue
//
//  channel  | valid         | ready         | data
//  ---------+---------------+---------------+-------------------------------
//  input    | item_valid    | item_ready    | item   (mode, key, payload)
//  output   | result_valid  | result_ready  | result (key, payload, status, count)
//
// push: free-slot pick, bucket index unit (BKT_A, BKT_B), tail read and link
//   write, then the result register; a push on a full heap skips to the result.
// pop: an empty heap finishes at the scan; when bucket 0 holds entries its head
//   is read and taken; otherwise the bucket is walked for its minimum, each entry
//   is re-filed, then a rescan; the single-port link walk keeps this serial.
// synchronous active-high reset clears counters and bucket flags; entry stores
//   need no clearing.
// a result waiting on result_ready holds only the final step; a new item is
//   taken the cycle after the result register is loaded.
`default_nettype none
module radix_heap_priority_queue #(
  parameter int CAPACITY      = rhpq_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_WIDTH = rhpq_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire rhpq_pkg::in_item_t   item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output rhpq_pkg::out_item_t       result
);
  import rhpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rhpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .sts(sts), .cmd(cmd));

  rhpq_dp #(.CAPACITY(CAPACITY), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .sts(sts),
    .result(result), .result_valid(result_valid), .result_ready(result_ready));
endmodule
`default_nettype wire
